// ===== rtl/smal_pkg.sv =====
package smal_pkg;

    localparam int DATA_W      = 32;
    localparam int WIDE_W      = DATA_W + 2;
    localparam int GAIN_W      = 31;
    localparam int BOUND_W     = 26;
    localparam int CFG_INDEX_W = 8;
    localparam int PROD_W      = DATA_W + GAIN_W;

    // tanh argument: z = (|s| << Z_SHIFT) / boundary, Q30
    localparam int Z_SHIFT = 24;
    localparam int Z_QBITS = 27;
    localparam int Z_PRE   = Z_QBITS - Z_SHIFT;
    localparam int T_W     = 28;

    // double-angle steps t = 2t / (1 + t^2), Q30
    localparam int Q_W       = 31;
    localparam int DBL_DBITS = 32;
    localparam int DBL_STEPS = 6;
    localparam logic [Q_W-1:0] Q_ONE = 31'h4000_0000;

    // reciprocals for the constant divisions in the series
    localparam logic [21:0] RECIP3     = 22'd2796203;
    localparam int          RECIP3_SH  = 23;
    localparam logic [16:0] RECIP15    = 17'd69906;
    localparam int          RECIP15_SH = 20;
    localparam logic [16:0] RECIP315   = 17'd106523;
    localparam int          RECIP315_SH = 25;

    localparam int KV_RESET_UNITS    = 20;
    localparam int KP_RESET_UNITS    = 100;
    localparam int BOUND_RESET_UNITS = 100;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 34'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -34'sd2147483648;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ACCEL_GAIN     = CFG_INDEX_W'(0),
        REG_VELOCITY_GAIN  = CFG_INDEX_W'(1),
        REG_ROBUST_GAIN    = CFG_INDEX_W'(2),
        REG_BOUNDARY_WIDTH = CFG_INDEX_W'(3)
    } cfg_reg_t;

    // per-item values that ride along with the tanh evaluation
    typedef struct packed {
        logic signed [DATA_W:0] sum_av;
        logic                   neg;
        logic                   flag;
        logic                   tsat;
    } side_t;

    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] val;
    } clip_t;

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
        logic [DATA_W-1:0] u;
        u = $unsigned(x);
        return x[DATA_W-1] ? (~u + DATA_W'(1)) : u;
    endfunction

    function automatic clip_t clip34(input logic signed [WIDE_W-1:0] v);
        clip_t c;
        if (v > SAT_MAX)
        begin
            c.clip = 1'b1;
            c.val  = DATA_W'(SAT_MAX);
        end
        else if (v < SAT_MIN)
        begin
            c.clip = 1'b1;
            c.val  = DATA_W'(SAT_MIN);
        end
        else
        begin
            c.clip = 1'b0;
            c.val  = DATA_W'(v);
        end
        return c;
    endfunction

endpackage

// ===== rtl/sliding_mode_accel_law_core.sv =====
// sliding-mode acceleration law with a tanh boundary layer
//
// request channel: item_valid/item_stall carry position_error, velocity_error and
// reference_accel (signed fixed point, FRAC_BITS fraction bits). result channel:
// result_valid/result_stall carry desired_accel and the saturated flag, one result
// per request, in order. config channel: cfg_valid/cfg_ready with cfg_index 0..3
// (accel, velocity, robust gain, boundary width); other indexes are dropped. write
// config only while no request is in flight. cfg_ready is always high.
//
// fully pipelined, 231 register stages, and one request can be taken every cycle
// while no stalled result holds the pipeline. the depth is set by the bit-per-stage
// dividers: 27 stages for the surface ratio and 31 for each of the six double-angle
// steps of tanh.
//
// reset clears all valid bits and loads the default gains. a stalled result holds
// the whole pipeline in place, so item_stall follows result_stall while a result is
// waiting; bubbles never stall the request side.
module sliding_mode_accel_law_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic signed [smal_pkg::DATA_W-1:0]   position_error,
    input  logic signed [smal_pkg::DATA_W-1:0]   velocity_error,
    input  logic signed [smal_pkg::DATA_W-1:0]   reference_accel,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [smal_pkg::DATA_W-1:0]   desired_accel,
    output logic                                 saturated,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [smal_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [smal_pkg::DATA_W-1:0]          cfg_data
);
    import smal_pkg::*;

    localparam logic [GAIN_W-1:0]  KA_RESET = GAIN_W'(longint'(1) << FRAC_BITS);
    localparam logic [GAIN_W-1:0]  KV_RESET =
        GAIN_W'(longint'(KV_RESET_UNITS) << FRAC_BITS);
    localparam logic [GAIN_W-1:0]  KP_RESET =
        GAIN_W'(longint'(KP_RESET_UNITS) << FRAC_BITS);
    localparam logic [BOUND_W-1:0] BOUND_RESET =
        BOUND_W'(longint'(BOUND_RESET_UNITS) << FRAC_BITS);

    logic               adv;
    logic [GAIN_W-1:0]  ka_reg, kv_reg, kp_reg;
    logic [BOUND_W-1:0] bound_reg;
    logic [BOUND_W-1:0] bound_eff;

    logic               fr_valid;
    logic [BOUND_W-1:0] fr_rem, fr_divisor;
    logic [Z_QBITS-1:0] fr_low;
    side_t              fr_side;

    logic               zd_valid;
    logic [Z_QBITS-1:0] zd_quot;
    side_t              zd_side;

    logic               po_valid;
    logic [T_W-1:0]     po_t;
    side_t              po_side;

    logic               dbl_valid [DBL_STEPS+1];
    logic [Q_W-1:0]     dbl_t     [DBL_STEPS+1];
    side_t              dbl_side  [DBL_STEPS+1];

    logic [Q_W-1:0]     th;
    logic [2*Q_W-1:0]   rb_prod;
    logic [Q_W-1:0]     rm_reg;
    side_t              rb_side_reg;
    logic               rb_valid_reg;

    logic signed [WIDE_W-1:0] r_wide, total;
    clip_t                    res_next;
    logic signed [DATA_W-1:0] desired_accel_reg;
    logic                     saturated_reg;
    logic                     result_valid_reg;

    assign adv        = !(result_valid_reg && result_stall);
    assign item_stall = !adv;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ka_reg    <= KA_RESET;
            kv_reg    <= KV_RESET;
            kp_reg    <= KP_RESET;
            bound_reg <= BOUND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACCEL_GAIN:     ka_reg    <= cfg_data[GAIN_W-1:0];
                REG_VELOCITY_GAIN:  kv_reg    <= cfg_data[GAIN_W-1:0];
                REG_ROBUST_GAIN:    kp_reg    <= cfg_data[GAIN_W-1:0];
                REG_BOUNDARY_WIDTH: bound_reg <= cfg_data[BOUND_W-1:0];
                default:            ;
            endcase
        end
    end

    // a zero width acts as one lsb
    assign bound_eff = (bound_reg == '0) ? BOUND_W'(1) : bound_reg;

    smal_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (item_valid),
        .position_error  (position_error),
        .velocity_error  (velocity_error),
        .reference_accel (reference_accel),
        .accel_gain      (ka_reg),
        .velocity_gain   (kv_reg),
        .boundary        (bound_eff),
        .out_valid       (fr_valid),
        .rem             (fr_rem),
        .low             (fr_low),
        .divisor         (fr_divisor),
        .side            (fr_side)
    );

    smal_div #(
        .QBITS (Z_QBITS),
        .DBITS (BOUND_W)
    ) u_zdiv (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (fr_valid),
        .rem_in     (fr_rem),
        .low_in     (fr_low),
        .divisor_in (fr_divisor),
        .side_in    (fr_side),
        .out_valid  (zd_valid),
        .quot       (zd_quot),
        .side_out   (zd_side)
    );

    smal_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (zd_valid),
        .z         (zd_quot),
        .side_in   (zd_side),
        .out_valid (po_valid),
        .t         (po_t),
        .side_out  (po_side)
    );

    assign dbl_valid[0] = po_valid;
    assign dbl_t[0]     = Q_W'(po_t);
    assign dbl_side[0]  = po_side;

    for (genvar k = 0; k < DBL_STEPS; k++)
    begin : g_dbl
        smal_dbl u_dbl (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dbl_valid[k]),
            .t_in      (dbl_t[k]),
            .side_in   (dbl_side[k]),
            .out_valid (dbl_valid[k+1]),
            .t_out     (dbl_t[k+1]),
            .side_out  (dbl_side[k+1])
        );
    end

    // past eight boundary widths tanh is exactly one
    assign th      = dbl_side[DBL_STEPS].tsat ? Q_ONE : dbl_t[DBL_STEPS];
    assign rb_prod = (2*Q_W)'(kp_reg) * (2*Q_W)'(th);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rb_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rb_valid_reg     <= dbl_valid[DBL_STEPS];
            result_valid_reg <= rb_valid_reg;
        end
    end

    assign r_wide   = rb_side_reg.neg ? -$signed({3'b000, rm_reg}) : $signed({3'b000, rm_reg});
    assign total    = $signed({rb_side_reg.sum_av[DATA_W], rb_side_reg.sum_av}) - r_wide;
    assign res_next = clip34(total);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rm_reg            <= rb_prod[2*Q_W-2:30];
            rb_side_reg       <= dbl_side[DBL_STEPS];
            desired_accel_reg <= res_next.val;
            saturated_reg     <= rb_side_reg.flag | res_next.clip;
        end
    end

    assign result_valid  = result_valid_reg;
    assign desired_accel = desired_accel_reg;
    assign saturated     = saturated_reg;

endmodule

// ===== rtl/smal_div.sv =====
module smal_div #(
    parameter int QBITS = 27,
    parameter int DBITS = 26
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [DBITS-1:0] rem_in,
    input  logic [QBITS-1:0] low_in,
    input  logic [DBITS-1:0] divisor_in,
    input  smal_pkg::side_t  side_in,
    output logic             out_valid,
    output logic [QBITS-1:0] quot,
    output smal_pkg::side_t  side_out
);
    import smal_pkg::*;

    // one quotient bit per stage; dividend bits shift out of qs as quotient bits shift in
    logic [QBITS-1:0] valid_reg;
    logic [DBITS-1:0] rem_reg  [QBITS];
    logic [DBITS-1:0] rem_next [QBITS];
    logic [QBITS-1:0] qs_reg   [QBITS];
    logic [QBITS-1:0] qs_next  [QBITS];
    logic [DBITS-1:0] div_reg  [QBITS];
    side_t            side_reg [QBITS];

    always_comb
    begin : div_steps
        logic [DBITS-1:0] rem_src;
        logic [QBITS-1:0] qs_src;
        logic [DBITS-1:0] div_src;
        logic [DBITS:0]   trial;
        for (int k = 0; k < QBITS; k++)
        begin
            if (k == 0)
            begin
                rem_src = rem_in;
                qs_src  = low_in;
                div_src = divisor_in;
            end
            else
            begin
                rem_src = rem_reg[k-1];
                qs_src  = qs_reg[k-1];
                div_src = div_reg[k-1];
            end
            trial = {rem_src, qs_src[QBITS-1]};
            if (trial >= {1'b0, div_src})
            begin
                rem_next[k] = DBITS'(trial - {1'b0, div_src});
                qs_next[k]  = {qs_src[QBITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[DBITS-1:0];
                qs_next[k]  = {qs_src[QBITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[QBITS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < QBITS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                qs_reg[k]  <= qs_next[k];
                if (k == 0)
                begin
                    div_reg[k]  <= divisor_in;
                    side_reg[k] <= side_in;
                end
                else
                begin
                    div_reg[k]  <= div_reg[k-1];
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[QBITS-1];
    assign quot      = qs_reg[QBITS-1];
    assign side_out  = side_reg[QBITS-1];

endmodule

// ===== rtl/smal_front.sv =====
module smal_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic signed [smal_pkg::DATA_W-1:0] position_error,
    input  logic signed [smal_pkg::DATA_W-1:0] velocity_error,
    input  logic signed [smal_pkg::DATA_W-1:0] reference_accel,
    input  logic [smal_pkg::GAIN_W-1:0]        accel_gain,
    input  logic [smal_pkg::GAIN_W-1:0]        velocity_gain,
    input  logic [smal_pkg::BOUND_W-1:0]       boundary,
    output logic                               out_valid,
    output logic [smal_pkg::BOUND_W-1:0]       rem,
    output logic [smal_pkg::Z_QBITS-1:0]       low,
    output logic [smal_pkg::BOUND_W-1:0]       divisor,
    output smal_pkg::side_t                    side
);
    import smal_pkg::*;

    logic [3:0] valid_reg;

    // stage a: gain products on magnitudes
    logic [PROD_W-1:0]        pa_reg, pp_reg, pv_reg;
    logic [PROD_W-1:0]        pa_next, pp_next, pv_next;
    logic                     na_reg, np_reg, nv_reg;
    logic signed [DATA_W-1:0] verr_a_reg;

    // stage b: scaled and clipped terms
    logic signed [DATA_W-1:0] a_reg, p_reg, v_reg, verr_b_reg;
    clip_t                    a_next, p_next, v_next;
    logic                     flag_b_reg;

    // stage c: surface and feedforward sum
    logic signed [WIDE_W-1:0] s_wide;
    clip_t                    s_next;
    logic [DATA_W-1:0]        smag_reg;
    logic                     neg_c_reg, flag_c_reg;
    logic signed [DATA_W:0]   sum_reg, sum_next;

    // stage d: divider operands
    logic                     tsat_next;
    logic [BOUND_W-1:0]       rem_reg, divisor_reg;
    logic [Z_QBITS-1:0]       low_reg;
    side_t                    side_reg;

    function automatic clip_t gain_clip(input logic [PROD_W-1:0] prod, input logic neg);
        logic [PROD_W-1:0]      q;
        logic [DATA_W:0]        qc;
        logic signed [WIDE_W-1:0] w;
        q  = prod >> FRAC_BITS;
        // anything at or above 2^33 clips either way
        qc = (|q[PROD_W-1:DATA_W+1]) ? {(DATA_W+1){1'b1}} : q[DATA_W:0];
        w  = $signed({1'b0, qc});
        if (neg)
            w = -w;
        return clip34(w);
    endfunction

    assign pa_next = PROD_W'(mag32(reference_accel)) * PROD_W'(accel_gain);
    assign pp_next = PROD_W'(mag32(position_error)) * PROD_W'(velocity_gain);
    assign pv_next = PROD_W'(mag32(velocity_error)) * PROD_W'(velocity_gain);

    assign a_next = gain_clip(pa_reg, na_reg);
    assign p_next = gain_clip(pp_reg, np_reg);
    assign v_next = gain_clip(pv_reg, nv_reg);

    assign s_wide = -$signed({{2{verr_b_reg[DATA_W-1]}}, verr_b_reg})
                    - $signed({{2{p_reg[DATA_W-1]}}, p_reg});
    assign s_next   = clip34(s_wide);
    assign sum_next = $signed({a_reg[DATA_W-1], a_reg}) + $signed({v_reg[DATA_W-1], v_reg});

    assign tsat_next = smag_reg >= DATA_W'({boundary, {Z_PRE{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg     <= pa_next;
            pp_reg     <= pp_next;
            pv_reg     <= pv_next;
            na_reg     <= reference_accel[DATA_W-1];
            np_reg     <= position_error[DATA_W-1];
            nv_reg     <= velocity_error[DATA_W-1];
            verr_a_reg <= velocity_error;

            a_reg      <= a_next.val;
            p_reg      <= p_next.val;
            v_reg      <= v_next.val;
            verr_b_reg <= verr_a_reg;
            flag_b_reg <= a_next.clip | p_next.clip | v_next.clip;

            smag_reg   <= mag32(s_next.val);
            neg_c_reg  <= s_next.val[DATA_W-1];
            sum_reg    <= sum_next;
            flag_c_reg <= flag_b_reg | s_next.clip;

            rem_reg         <= smag_reg[BOUND_W+Z_PRE-1:Z_PRE];
            low_reg         <= {smag_reg[Z_PRE-1:0], {Z_SHIFT{1'b0}}};
            divisor_reg     <= boundary;
            side_reg.sum_av <= sum_reg;
            side_reg.neg    <= neg_c_reg;
            side_reg.flag   <= flag_c_reg;
            side_reg.tsat   <= tsat_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign rem       = rem_reg;
    assign low       = low_reg;
    assign divisor   = divisor_reg;
    assign side      = side_reg;

endmodule

// ===== rtl/smal_poly.sv =====
module smal_poly (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [smal_pkg::Z_QBITS-1:0] z,
    input  smal_pkg::side_t              side_in,
    output logic                         out_valid,
    output logic [smal_pkg::T_W-1:0]     t,
    output smal_pkg::side_t              side_out
);
    import smal_pkg::*;

    // odd series to z^7, one power per stage
    logic [5:0]   valid_reg;
    side_t        side_reg [6];

    logic [53:0]  z2_prod;
    logic [50:0]  z3_prod;
    logic [44:0]  z5_prod;
    logic [38:0]  z7_prod;
    logic [42:0]  q3_prod;
    logic [32:0]  q15_prod;
    logic [13:0]  z7x17;
    logic [30:0]  q315_prod;

    logic [Z_QBITS-1:0] s1_z_reg, s2_z_reg, s3_z_reg, s4_z_reg, s5_z_reg;
    logic [23:0]        s1_z2_reg, s2_z2_reg, s3_z2_reg;
    logic [20:0]        s2_z3_reg, s3_z3_reg, s4_z3_reg;
    logic [14:0]        s3_z5_reg, s4_z5_reg;
    logic [8:0]         s4_z7_reg;
    logic [19:0]        s5_q3_reg;
    logic [12:0]        s5_q15_reg;
    logic [5:0]         s5_q315_reg;
    logic [T_W-1:0]     s6_t_reg, s6_t_next;

    assign z2_prod   = 54'(z) * 54'(z);
    assign z3_prod   = 51'(s1_z2_reg) * 51'(s1_z_reg);
    assign z5_prod   = 45'(s2_z3_reg) * 45'(s2_z2_reg);
    assign z7_prod   = 39'(s3_z5_reg) * 39'(s3_z2_reg);
    assign q3_prod   = 43'(s4_z3_reg) * 43'(RECIP3);
    assign q15_prod  = 33'({s4_z5_reg, 1'b0}) * 33'(RECIP15);
    assign z7x17     = 14'({s4_z7_reg, 4'b0000}) + 14'(s4_z7_reg);
    assign q315_prod = 31'(z7x17) * 31'(RECIP315);
    assign s6_t_next = T_W'(s5_z_reg) - T_W'(s5_q3_reg) + T_W'(s5_q15_reg)
                       - T_W'(s5_q315_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < 6; k++)
                side_reg[k] <= side_reg[k-1];

            s1_z_reg  <= z;
            s1_z2_reg <= z2_prod[53:30];

            s2_z_reg  <= s1_z_reg;
            s2_z2_reg <= s1_z2_reg;
            s2_z3_reg <= z3_prod[50:30];

            s3_z_reg  <= s2_z_reg;
            s3_z2_reg <= s2_z2_reg;
            s3_z3_reg <= s2_z3_reg;
            s3_z5_reg <= z5_prod[44:30];

            s4_z_reg  <= s3_z_reg;
            s4_z3_reg <= s3_z3_reg;
            s4_z5_reg <= s3_z5_reg;
            s4_z7_reg <= z7_prod[38:30];

            s5_z_reg    <= s4_z_reg;
            s5_q3_reg   <= q3_prod[42:RECIP3_SH];
            s5_q15_reg  <= q15_prod[32:RECIP15_SH];
            s5_q315_reg <= q315_prod[30:RECIP315_SH];

            s6_t_reg <= s6_t_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign t         = s6_t_reg;
    assign side_out  = side_reg[5];

endmodule

// ===== rtl/smal_dbl.sv =====
module smal_dbl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [smal_pkg::Q_W-1:0] t_in,
    input  smal_pkg::side_t          side_in,
    output logic                     out_valid,
    output logic [smal_pkg::Q_W-1:0] t_out,
    output smal_pkg::side_t          side_out
);
    import smal_pkg::*;

    logic [2*Q_W-1:0]     sq_prod;
    logic [DBL_DBITS-1:0] d_reg, d_next;
    logic [Q_W-1:0]       t_reg;
    side_t                side_reg;
    logic                 valid_reg;
    logic [Q_W-1:0]       quot;

    // d = 1 + t^2 in Q30
    assign sq_prod = (2*Q_W)'(t_in) * (2*Q_W)'(t_in);
    assign d_next  = DBL_DBITS'(Q_ONE) + sq_prod[2*Q_W-1:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg    <= d_next;
            t_reg    <= t_in;
            side_reg <= side_in;
        end
    end

    // (t << 31) / d, with t < d so the top half starts as the remainder
    smal_div #(
        .QBITS (Q_W),
        .DBITS (DBL_DBITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (valid_reg),
        .rem_in     (DBL_DBITS'(t_reg)),
        .low_in     ('0),
        .divisor_in (d_reg),
        .side_in    (side_reg),
        .out_valid  (out_valid),
        .quot       (quot),
        .side_out   (side_out)
    );

    assign t_out = (quot > Q_ONE) ? Q_ONE : quot;

endmodule

// ===== rtl/sliding_mode_accel_law_core_chk.sv =====
module sliding_mode_accel_law_core_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_valid,
    input logic                               item_stall,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic signed [smal_pkg::DATA_W-1:0] desired_accel,
    input logic                               saturated,
    input logic                               cfg_ready
);
    import smal_pkg::*;

    // a held result keeps its value
    property p_result_hold;
        @(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(desired_accel) && $stable(saturated);
    endproperty
    a_result_hold: assert property (p_result_hold)
        else $error("held result changed");

    // the request side stalls exactly when a finished result is held
    property p_stall_link;
        @(posedge clk) disable iff (!rst_n)
        1'b1 |-> (item_stall == (result_valid && result_stall));
    endproperty
    a_stall_link: assert property (p_stall_link)
        else $error("request stall does not follow result stall");

    // nothing comes out right after reset
    property p_reset_empty;
        @(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("result valid right after reset");

    // a request can only be refused while a result is held
    property p_accept_free;
        @(posedge clk) disable iff (!rst_n)
        item_valid && !result_valid |-> !item_stall && cfg_ready;
    endproperty
    a_accept_free: assert property (p_accept_free)
        else $error("request refused with no result held");

endmodule

bind sliding_mode_accel_law_core sliding_mode_accel_law_core_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .desired_accel (desired_accel),
    .saturated     (saturated),
    .cfg_ready     (cfg_ready)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import smal_pkg::*;

    localparam int FRAC_BITS        = 16;
    localparam int ONE_Q            = 1 << FRAC_BITS;
    localparam int CLK_PERIOD       = 10;
    localparam int PIPE_LATENCY     = 231;
    localparam int RUN_LIMIT_CYCLES = 200000;
    localparam int IDLE_PCT         = 26;
    localparam int STALL_HOLD       = 600;
    localparam int PRESSURE_REQS    = 250;
    localparam int PHASE_REQS       = 25;
    localparam int MAX_PRINTED      = 60;
    localparam int FIRST_SPARE_REG  = 4;
    localparam int LAST_REG_INDEX   = (1 << CFG_INDEX_W) - 1;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint unsigned TANH_ONE = 64'd1 << 30;

    typedef struct {
        logic signed [DATA_W-1:0] pos_err;
        logic signed [DATA_W-1:0] vel_err;
        logic signed [DATA_W-1:0] ref_acc;
    } accel_req_t;

    typedef struct {
        logic signed [DATA_W-1:0] accel;
        logic                     clipped;
    } accel_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_stall;
    logic signed [DATA_W-1:0] position_error;
    logic signed [DATA_W-1:0] velocity_error;
    logic signed [DATA_W-1:0] reference_accel;
    logic                     result_valid;
    logic                     result_stall;
    logic signed [DATA_W-1:0] desired_accel;
    logic                     saturated;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]        cfg_data;

    // gain and layer settings as the block should hold them
    longint unsigned accel_k;
    longint unsigned vel_k;
    longint unsigned robust_k;
    longint unsigned layer_w;

    accel_req_t    pending_reqs[$];
    accel_result_t expected_accel[$];
    accel_result_t want_res;

    bit item_taken;
    int src_idle_pct;
    int dst_idle_pct;
    int sink_hold;
    int err_count;
    int reqs_accepted;
    int results_seen;
    int clipped_seen;
    int settings_used;

    sliding_mode_accel_law_core #(
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .position_error  (position_error),
        .velocity_error  (velocity_error),
        .reference_accel (reference_accel),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .desired_accel   (desired_accel),
        .saturated       (saturated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    // gain product on the magnitude, truncated toward zero
    function automatic longint apply_gain(input longint x, input longint unsigned g);
        longint unsigned mag;
        longint unsigned q;
        mag = (x < 0) ? longint'(-x) : longint'(x);
        q = (mag * g) >> FRAC_BITS;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp32(input longint v, inout bit clipped);
        if (v > S32_MAX)
        begin
            clipped = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN)
        begin
            clipped = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    function automatic accel_result_t predict_accel(input logic signed [DATA_W-1:0] perr_w,
                                                    input logic signed [DATA_W-1:0] verr_w,
                                                    input logic signed [DATA_W-1:0] aref_w);
        longint perr, verr, aref, a, p, s, v, r;
        longint unsigned b, smag, z, z2, z3, z5, z7, t, d, rm;
        bit clipped;
        int i;
        accel_result_t res;
        clipped = 1'b0;
        perr = perr_w;
        verr = verr_w;
        aref = aref_w;
        // a zero layer width acts as one lsb
        b = (layer_w == 0) ? 64'd1 : layer_w;
        a = clamp32(apply_gain(aref, accel_k), clipped);
        p = clamp32(apply_gain(perr, vel_k), clipped);
        s = clamp32(-verr - p, clipped);
        v = clamp32(apply_gain(verr, vel_k), clipped);
        smag = (s < 0) ? longint'(-s) : longint'(s);
        if (smag >= (b << 3))
        begin
            t = TANH_ONE;
        end
        else
        begin
            // series on x/64, then six double-angle steps
            z  = (smag << Z_SHIFT) / b;
            z2 = (z * z) >> 30;
            z3 = (z2 * z) >> 30;
            z5 = (z3 * z2) >> 30;
            z7 = (z5 * z2) >> 30;
            t = z - z3 / 3 + (2 * z5) / 15;
            t = t - (17 * z7) / 315;
            for (i = 0; i < DBL_STEPS; i++)
            begin
                d = TANH_ONE + ((t * t) >> 30);
                t = (t << 31) / d;
                if (t > TANH_ONE)
                begin
                    t = TANH_ONE;
                end
            end
        end
        rm = (robust_k * t) >> 30;
        r = (s < 0) ? -longint'(rm) : longint'(rm);
        res.accel = DATA_W'(clamp32(a + v - r, clipped));
        res.clipped = clipped;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] scaled_word(input int min_shift);
        logic [DATA_W-1:0] w;
        w = $urandom >> $urandom_range(DATA_W - 1, min_shift);
        if ($urandom_range(1))
        begin
            w = -w;
        end
        return w;
    endfunction

    task automatic add_req(input logic signed [DATA_W-1:0] p,
                           input logic signed [DATA_W-1:0] v,
                           input logic signed [DATA_W-1:0] a);
        accel_req_t rq;
        rq.pos_err = p;
        rq.vel_err = v;
        rq.ref_acc = a;
        pending_reqs.push_back(rq);
    endtask

    task automatic queue_random(input int n);
        longint span;
        repeat (n)
        begin
            span = (layer_w == 0) ? 64'sd16 : longint'(layer_w << 4);
            if (span > S32_MAX)
            begin
                span = S32_MAX;
            end
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    add_req($urandom, $urandom, $urandom);
                end
                3, 4, 5:
                begin
                    add_req(scaled_word(0), scaled_word(0), scaled_word(0));
                end
                default:
                begin
                    // keep the surface inside the boundary layer most of the time
                    add_req(scaled_word(20),
                            DATA_W'(longint'($urandom_range(32'(span))) - span / 2),
                            scaled_word(0));
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_ACCEL_GAIN:     accel_k  = data[GAIN_W-1:0];
            REG_VELOCITY_GAIN:  vel_k    = data[GAIN_W-1:0];
            REG_ROBUST_GAIN:    robust_k = data[GAIN_W-1:0];
            REG_BOUNDARY_WIDTH: layer_w  = data[BOUND_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [DATA_W-1:0] ka, input logic [DATA_W-1:0] kv,
                                  input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] bw);
        write_reg(REG_ACCEL_GAIN, ka);
        write_reg(REG_VELOCITY_GAIN, kv);
        write_reg(REG_ROBUST_GAIN, kp);
        write_reg(REG_BOUNDARY_WIDTH, bw);
        settings_used++;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_accel.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                item_valid      <= 1'b1;
                position_error  <= pending_reqs[0].pos_err;
                velocity_error  <= pending_reqs[0].vel_err;
                reference_accel <= pending_reqs[0].ref_acc;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // result receiver, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            result_stall <= 1'b1;
            sink_hold = sink_hold - 1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < dst_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_taken = item_valid && !item_stall;
            if (item_taken)
            begin
                expected_accel.push_back(predict_accel(position_error, velocity_error,
                                                       reference_accel));
                void'(pending_reqs.pop_front());
                reqs_accepted++;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_accel.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result: desired_accel %0d saturated %b",
                                              desired_accel, saturated));
                end
                else
                begin
                    want_res = expected_accel.pop_front();
                    if (desired_accel !== want_res.accel)
                    begin
                        report_mismatch($sformatf("result %0d desired_accel %0d, want %0d",
                                                  results_seen, desired_accel, want_res.accel));
                    end
                    if (saturated !== want_res.clipped)
                    begin
                        report_mismatch($sformatf("result %0d saturated %b, want %b",
                                                  results_seen, saturated, want_res.clipped));
                    end
                    if (want_res.clipped)
                    begin
                        clipped_seen++;
                    end
                    results_seen++;
                end
            end
        end
    end

    initial
    begin
        repeat (RUN_LIMIT_CYCLES) @(posedge clk);
        $display("timeout: %0d requests pending, %0d results outstanding",
                 pending_reqs.size(), expected_accel.size());
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        position_error  = '0;
        velocity_error  = '0;
        reference_accel = '0;
        result_stall    = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        item_taken      = 1'b0;
        sink_hold       = 0;
        src_idle_pct    = IDLE_PCT;
        dst_idle_pct    = IDLE_PCT;
        err_count       = 0;
        reqs_accepted   = 0;
        results_seen    = 0;
        clipped_seen    = 0;
        settings_used   = 1;
        accel_k         = longint'(ONE_Q);
        vel_k           = longint'(KV_RESET_UNITS * ONE_Q);
        robust_k        = longint'(KP_RESET_UNITS * ONE_Q);
        layer_w         = longint'(BOUND_RESET_UNITS * ONE_Q);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset gains: field extremes, clips and the tanh limit
        add_req(0, 0, 0);
        add_req(32'sh7FFF_FFFF, 0, 0);
        add_req(32'sh8000_0000, 0, 0);
        add_req(0, 32'sh7FFF_FFFF, 0);
        add_req(0, 32'sh8000_0000, 0);
        add_req(0, 0, 32'sh7FFF_FFFF);
        add_req(0, 0, 32'sh8000_0000);
        add_req(-1, -1, 1);
        add_req(1, 1, -1);
        add_req(0, 10 * ONE_Q, 32'sh7FFF_FFFF);
        add_req(0, -1000 * ONE_Q, 0);
        add_req(0, -800 * ONE_Q, 0);
        add_req(0, -800 * ONE_Q + 1, 0);
        add_req(0, 800 * ONE_Q - 1, 5 * ONE_Q);
        add_req(ONE_Q, -20 * ONE_Q, 0);
        add_req(0, 50 * ONE_Q, -3 * ONE_Q);
        add_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        add_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        add_req(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
        add_req(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
        wait_drained();

        // over-wide writes get masked, zero width acts as one lsb, spare indexes do nothing
        apply_settings(32'hFFFF_FFFF, 0, 0, 0);
        write_reg(CFG_INDEX_W'($urandom_range(LAST_REG_INDEX, FIRST_SPARE_REG)), $urandom);
        queue_random(PHASE_REQS);
        wait_drained();

        apply_settings(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        queue_random(PHASE_REQS);
        wait_drained();

        apply_settings(ONE_Q, ONE_Q, 100 * ONE_Q, 32'hFFFF_FFFF);
        write_reg(CFG_INDEX_W'(LAST_REG_INDEX), 32'hFFFF_FFFF);
        queue_random(PHASE_REQS);
        wait_drained();

        apply_settings(2 * ONE_Q, ONE_Q / 2, 32'hFFFF_FFFF, ONE_Q);
        queue_random(PHASE_REQS);
        wait_drained();

        apply_settings($urandom >> 12, $urandom >> 12, $urandom >> 8, 1000 * ONE_Q);
        queue_random(PHASE_REQS);
        wait_drained();

        apply_settings($urandom, $urandom >> $urandom_range(31, 8),
                       $urandom >> $urandom_range(31, 4), $urandom >> $urandom_range(31, 6));
        queue_random(PHASE_REQS);
        wait_drained();

        // back-pressure: sink holds off long enough for the pipe to fill and stall requests
        apply_settings(ONE_Q, 20 * ONE_Q, 100 * ONE_Q, $urandom >> $urandom_range(31, 8));
        src_idle_pct = 0;
        dst_idle_pct = 0;
        sink_hold    = STALL_HOLD;
        queue_random(PRESSURE_REQS);
        wait_drained();
        src_idle_pct = IDLE_PCT;
        dst_idle_pct = IDLE_PCT;

        repeat (PIPE_LATENCY + 20) @(posedge clk);
        if (expected_accel.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_accel.size()));
        end
        $display("run covered %0d requests over %0d gain settings, %0d results clipped",
                 reqs_accepted, settings_used, clipped_seen);
        $display("results checked: %0d, mismatches: %0d", results_seen, err_count);
        if (err_count == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
